FILE: src/tics_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tics_pkg: shared types and constants
// Widths, register addresses, sequencer states and the status struct of the
// multiply/divide unit used by the inverse-CDF sampler.
// ----------------------------------------------------------------------------
package tics_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SPAN_W = 33;
  localparam int unsigned VAL_W  = 17;
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned ADDR_W = 3;

  localparam logic REG_RANGE_MIN = 1'b0;
  localparam logic REG_RANGE_MAX = 1'b1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [DATA_W-1:0] RANGE_MIN_RST = 32'h0000_0000;
  localparam logic [DATA_W-1:0] RANGE_MAX_RST = 32'h0001_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH_L,
    ST_FETCH_R,
    ST_PREP1,
    ST_PREP2,
    ST_PREP3,
    ST_START,
    ST_WAIT,
    ST_FIX,
    ST_SUM
  } tics_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } tics_md_e;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } tics_md_sts_t;

endpackage

FILE: src/tics_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tics_ram: generic single-port-write, single-port-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tics_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 257
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tics_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tics_muldiv: iterative multiply then divide on one shared adder
// Forms mcand * mplier by shift-and-add, one bit per cycle, then divides the
// product by the divisor with restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module tics_muldiv import tics_pkg::*; #(
  parameter int unsigned TW = 26,
  parameter int unsigned DW = 26
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SPAN_W-1:0]      mcand_i,
  input  logic [TW-1:0]          mplier_i,
  input  logic [DW-1:0]          divisor_i,
  output logic [SPAN_W+TW-1:0]   quot_o,
  output tics_md_sts_t           sts_o
);

  localparam int unsigned PW   = SPAN_W + TW;
  localparam int unsigned SW   = SPAN_W + 1;
  localparam int unsigned CNTW = $clog2(PW);

  tics_md_e            phase_d, phase_q;
  logic [CNTW-1:0]     cnt_d, cnt_q;
  logic [PW-1:0]       p_d, p_q;
  logic [DW-1:0]       r_d, r_q;
  logic [SPAN_W-1:0]   mcand_d, mcand_q;
  logic [DW-1:0]       den_d, den_q;
  logic                done_d, done_q;

  logic [SW-1:0]       add_a, add_b;
  logic                add_sub;
  logic [SW:0]         add_s;
  logic [DW:0]         rs;
  logic                ge;

  assign add_s = {1'b0, add_a} + {1'b0, add_b ^ {SW{add_sub}}} + (SW + 1)'(add_sub);
  assign rs    = {r_q, p_q[PW-1]};
  assign ge    = add_s[SW];

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      MD_IDLE: begin
        if (start_i) begin
          phase_d = MD_MUL;
        end
      end
      MD_MUL: begin
        if (cnt_q == CNTW'(TW - 1)) begin
          phase_d = MD_DIV;
        end
      end
      MD_DIV: begin
        if (cnt_q == CNTW'(PW - 1)) begin
          phase_d = MD_IDLE;
        end
      end
      default: begin
        phase_d = MD_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    p_d     = p_q;
    r_d     = r_q;
    mcand_d = mcand_q;
    den_d   = den_q;
    done_d  = 1'b0;
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (phase_q)
      MD_IDLE: begin
        if (start_i) begin
          p_d     = PW'(mplier_i);
          mcand_d = mcand_i;
          den_d   = divisor_i;
          r_d     = '0;
          cnt_d   = '0;
        end
      end
      MD_MUL: begin
        add_a = {1'b0, p_q[PW-1:TW]};
        add_b = p_q[0] ? {1'b0, mcand_q} : '0;
        p_d   = {add_s[SW-1:0], p_q[TW-1:1]};
        cnt_d = (cnt_q == CNTW'(TW - 1)) ? '0 : cnt_q + 1'b1;
      end
      MD_DIV: begin
        add_a   = SW'(rs);
        add_b   = SW'(den_q);
        add_sub = 1'b1;
        r_d     = ge ? add_s[DW-1:0] : rs[DW-1:0];
        p_d     = {p_q[PW-2:0], ge};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNTW'(PW - 1)) begin
          done_d = 1'b1;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    r_q     <= r_d;
    mcand_q <= mcand_d;
    den_q   <= den_d;
  end

  assign quot_o       = p_q;
  assign sts_o.done   = done_q;
  assign sts_o.rem_nz = |r_q;

endmodule

FILE: src/tabulated_inverse_cdf_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabulated_inverse_cdf_sampler: inverse transform sampling on a CDF table
// Stores TABLE_STEPS+1 CDF points, scans for the interval that holds u and
// interpolates linearly inside it, giving a saturated signed Q16.16 sample.
//
//   Channel | Signals                                         | Direction
//   --------+-------------------------------------------------+----------
//   input   | in_valid_i/in_ready_o, operation_i, entry_*_i,  | in
//           | uniform_value_i                                 |
//   output  | out_valid_o/out_ready_i, sample_value_o,        | out
//           | interval_index_o, zero_width_o                  |
//   config  | psel, penable, pwrite, paddr, pwdata, prdata,   | in/out
//           | pready                                          |
//
// A sample beat first scans the table, one entry per cycle through the table
// RAM read port, until it finds the interval; the shared adder then takes
// TW = clog2(TABLE_STEPS+1) + 17 multiply steps and PW = TW + 33 divide
// steps. Input is not taken while a sample is in work. A finished result
// waits in the output register while a stalled output holds the final step.
// The table contents are undefined after reset.
// ----------------------------------------------------------------------------
module tabulated_inverse_cdf_sampler import tics_pkg::*; #(
  parameter int unsigned TABLE_STEPS = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic [VAL_W-1:0]         entry_value_i,
  input  logic [VAL_W-1:0]         uniform_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] sample_value_o,
  output logic [IDX_W-1:0]         interval_index_o,
  output logic                     zero_width_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int unsigned KW = $clog2(TABLE_STEPS + 1);
  localparam int unsigned TW = KW + 17;
  localparam int unsigned DW = KW + 17;
  localparam int unsigned PW = SPAN_W + TW;
  localparam int unsigned YW = PW + 2;
  localparam int unsigned CW = (KW > IDX_W) ? KW : IDX_W;
  localparam logic [KW-1:0] TS_K = KW'(TABLE_STEPS);
  localparam logic [CW-1:0] TS_C = CW'(TABLE_STEPS);
  localparam logic [DW-1:0] TS_D = DW'(TABLE_STEPS);

  tics_state_e               state_d, state_q;
  logic [DATA_W-1:0]         min_d, min_q, max_d, max_q;
  logic                      out_valid_d, out_valid_q;
  logic signed [DATA_W-1:0]  sample_d, sample_q;
  logic [IDX_W-1:0]          index_d, index_q;
  logic                      zw_d, zw_q;

  logic [VAL_W-1:0]          u_d, u_q;
  logic [KW-1:0]             k_d, k_q;
  logic [VAL_W-1:0]          fl_d, fl_q, fr_d, fr_q;
  logic signed [VAL_W:0]     d_d, d_q, diffu_d, diffu_q;
  logic signed [SPAN_W-1:0]  span_d, span_q;
  logic [KW-1:0]             km1_d, km1_q;
  logic                      dz_d, dz_q;
  logic signed [TW:0]        t_d, t_q;
  logic [VAL_W-1:0]          dmag_d, dmag_q;
  logic                      dneg_d, dneg_q;
  logic [TW-1:0]             tmag_d, tmag_q;
  logic [DW-1:0]             den_d, den_q;
  logic [SPAN_W-1:0]         spanmag_d, spanmag_q;
  logic                      neg_d, neg_q;
  logic signed [YW-1:0]      qs_d, qs_q;

  logic                      in_acc, out_acc, cfg_we, md_start;
  logic                      ram_we;
  logic [KW-1:0]             ram_waddr, ram_raddr;
  logic [VAL_W-1:0]          ram_rdata;
  logic [CW-1:0]             idx_ext, k_ext;
  logic                      hit;
  logic [KW-1:0]             kc;
  logic signed [KW+18:0]     prod, tfull;
  logic [YW-1:0]             qa;
  logic signed [YW-1:0]      y_full;
  logic [PW-1:0]             quot;
  tics_md_sts_t              md_sts;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_q && out_ready_i;
  assign cfg_we     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_RANGE_MAX) ? max_q : min_q;

  assign idx_ext   = CW'(entry_index_i);
  assign ram_waddr = idx_ext[KW-1:0];
  assign ram_we    = in_acc && (operation_i == OP_WRITE) && (idx_ext <= TS_C);
  assign hit       = (k_q == TS_K) || (u_q <= ram_rdata);
  assign kc        = (k_q == '0) ? KW'(1) : k_q;
  assign k_ext     = CW'(k_q);

  assign prod  = $signed({1'b0, km1_q}) * d_q;
  assign tfull = prod + {{(KW + 1){diffu_q[VAL_W]}}, diffu_q};
  assign qa    = {2'b00, quot} + YW'(md_sts.rem_nz);
  assign y_full = {{(YW - DATA_W){min_q[DATA_W-1]}}, min_q} + qs_q;

  tics_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_STEPS + 1)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (entry_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tics_muldiv #(
    .TW (TW),
    .DW (DW)
  ) u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (md_start),
    .mcand_i   (spanmag_q),
    .mplier_i  (tmag_q),
    .divisor_i (den_q),
    .quot_o    (quot),
    .sts_o     (md_sts)
  );

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (cfg_we) begin
      if (paddr[2] == REG_RANGE_MAX) begin
        max_d = pwdata;
      end else begin
        min_d = pwdata;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (operation_i == OP_SAMPLE)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_FETCH_L;
        end
      end
      ST_FETCH_L: state_d = ST_FETCH_R;
      ST_FETCH_R: state_d = ST_PREP1;
      ST_PREP1:   state_d = ST_PREP2;
      ST_PREP2:   state_d = ST_PREP3;
      ST_PREP3:   state_d = ST_START;
      ST_START:   state_d = ST_WAIT;
      ST_WAIT: begin
        if (md_sts.done) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX:     state_d = ST_SUM;
      ST_SUM: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_raddr   = '0;
    md_start    = 1'b0;
    u_d         = u_q;
    k_d         = k_q;
    fl_d        = fl_q;
    fr_d        = fr_q;
    d_d         = d_q;
    diffu_d     = diffu_q;
    span_d      = span_q;
    km1_d       = km1_q;
    dz_d        = dz_q;
    t_d         = t_q;
    dmag_d      = dmag_q;
    dneg_d      = dneg_q;
    tmag_d      = tmag_q;
    den_d       = den_q;
    spanmag_d   = spanmag_q;
    neg_d       = neg_q;
    qs_d        = qs_q;
    sample_d    = sample_q;
    index_d     = index_q;
    zw_d        = zw_q;
    out_valid_d = out_valid_q && !out_acc;
    unique case (state_q)
      ST_IDLE: begin
        u_d = uniform_value_i;
        k_d = '0;
      end
      ST_SCAN: begin
        if (hit) begin
          k_d       = kc;
          ram_raddr = kc - 1'b1;
        end else begin
          k_d       = k_q + 1'b1;
          ram_raddr = k_q + 1'b1;
        end
      end
      ST_FETCH_L: begin
        fl_d      = ram_rdata;
        ram_raddr = k_q;
      end
      ST_FETCH_R: begin
        fr_d = ram_rdata;
      end
      ST_PREP1: begin
        d_d     = $signed({1'b0, fr_q}) - $signed({1'b0, fl_q});
        diffu_d = $signed({1'b0, u_q}) - $signed({1'b0, fl_q});
        span_d  = $signed({max_q[DATA_W-1], max_q}) - $signed({min_q[DATA_W-1], min_q});
        km1_d   = k_q - 1'b1;
      end
      ST_PREP2: begin
        dz_d   = (d_q == '0);
        dneg_d = d_q[VAL_W];
        t_d    = (d_q == '0) ? $signed((TW + 1)'(km1_q)) : tfull[TW:0];
        dmag_d = (d_q == '0) ? VAL_W'(1) :
                 (d_q[VAL_W] ? VAL_W'(-d_q) : VAL_W'(d_q));
      end
      ST_PREP3: begin
        tmag_d    = t_q[TW] ? TW'(-t_q) : TW'(t_q);
        den_d     = TS_D * DW'(dmag_q);
        spanmag_d = span_q[SPAN_W-1] ? SPAN_W'(-span_q) : SPAN_W'(span_q);
        neg_d     = span_q[SPAN_W-1] ^ t_q[TW] ^ (dneg_q && !dz_q);
      end
      ST_START: begin
        md_start = 1'b1;
      end
      ST_WAIT: begin
        qs_d = qs_q;
      end
      ST_FIX: begin
        qs_d = neg_q ? -$signed(qa) : $signed({2'b00, quot});
      end
      ST_SUM: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          index_d     = k_ext[IDX_W-1:0];
          zw_d        = dz_q;
          if (!y_full[YW-1] && (|y_full[YW-2:DATA_W-1])) begin
            sample_d = {1'b0, {(DATA_W - 1){1'b1}}};
          end else if (y_full[YW-1] && !(&y_full[YW-2:DATA_W-1])) begin
            sample_d = {1'b1, {(DATA_W - 1){1'b0}}};
          end else begin
            sample_d = y_full[DATA_W-1:0];
          end
        end
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      min_q       <= RANGE_MIN_RST;
      max_q       <= RANGE_MAX_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      min_q       <= min_d;
      max_q       <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q       <= u_d;
    k_q       <= k_d;
    fl_q      <= fl_d;
    fr_q      <= fr_d;
    d_q       <= d_d;
    diffu_q   <= diffu_d;
    span_q    <= span_d;
    km1_q     <= km1_d;
    dz_q      <= dz_d;
    t_q       <= t_d;
    dmag_q    <= dmag_d;
    dneg_q    <= dneg_d;
    tmag_q    <= tmag_d;
    den_q     <= den_d;
    spanmag_q <= spanmag_d;
    neg_q     <= neg_d;
    qs_q      <= qs_d;
    sample_q  <= sample_d;
    index_q   <= index_d;
    zw_q      <= zw_d;
  end

  assign out_valid_o      = out_valid_q;
  assign sample_value_o   = sample_q;
  assign interval_index_o = index_q;
  assign zero_width_o     = zw_q;

endmodule
